// ----- sv/rpc_pkg.sv -----
package rpc_pkg;

   // Item codes.
   localparam logic OP_POSE  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_FOCAL_X       = 3'd0;
   localparam logic [2:0] CSR_FOCAL_Y       = 3'd1;
   localparam logic [2:0] CSR_CENTER_X      = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y      = 3'd3;
   localparam logic [2:0] CSR_INLIER_RADIUS = 3'd4;

   localparam logic [31:0] FOCAL_X_RESET       = 32'd32768000;
   localparam logic [31:0] FOCAL_Y_RESET       = 32'd32768000;
   localparam logic [31:0] CENTER_X_RESET      = 32'd20971520;
   localparam logic [31:0] CENTER_Y_RESET      = 32'd15728640;
   localparam logic [31:0] INLIER_RADIUS_RESET = 32'd131072;

   localparam int POSE_WORDS = 12;
   // Quotient bits resolved by the divider; results saturate at 2^QBITS - 1.
   localparam int QBITS = 31;
   // Divider latency: partial products, product sum, overflow check, one stage per bit.
   localparam int DIV_LAT = 3 + QBITS;

   typedef struct packed {
      logic               op;
      logic [3:0]         pose_index;
      logic signed [31:0] pose_value;
      logic               first_point;
      logic               point_present;
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic signed [31:0] key_u;
      logic signed [31:0] key_v;
   } req_word_type;

   typedef struct packed {
      logic        is_inlier;
      logic        depth_ok;
      logic [12:0] inlier_count;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] focal_x;
      logic [31:0] focal_y;
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] inlier_radius;
   } cfg_type;

   // Per-point values that ride alongside the projection datapath.
   typedef struct packed {
      logic               first_point;
      logic               depth_ok;
      logic               neg_x;
      logic               neg_y;
      logic signed [31:0] key_u;
      logic signed [31:0] key_v;
   } side_type;

endpackage

// ----- sv/reprojection_inlier_check_core.sv -----
// Reprojection inlier check. Each word on the req_ channel either loads one
// word of the 3x4 camera pose (op = 0, no response) or checks one point
// (op = 1, exactly one response word, in order). A point is mapped into the
// camera frame, projected through the pinhole model set by the csr_
// registers, and flagged as an inlier when it is present, its depth is
// positive and its pixel distance to the keypoint is within the radius; a
// saturating inlier count, restarted by first_point, comes back with every
// point. The block takes one word per cycle while rsp_ is not stalled. A
// point's response passes through the rigid transform stages, the projection
// divider (numerator partial products, their sum, an overflow check and one
// stage per quotient bit) and the scoring stages, the last of which is the
// output register.
// A pose load takes effect for every point accepted after it. A stall on rsp_
// holds the whole pipeline, so req_stall follows it while a response is waiting.
// The user must write registers only with no point in flight; nothing enforces it.
module reprojection_inlier_check_core #(
   parameter int MAX_POINTS = 4096,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rpc_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rpc_pkg::rsp_word_type  rsp_word,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wr_data
);

   localparam int CW = 66 - FRAC_BITS;

   logic                 en;
   logic                 req_accept;
   rpc_pkg::cfg_type     cfg_ff;
   logic [31:0]          pose_ff [rpc_pkg::POSE_WORDS];

   logic                 xf_valid;
   rpc_pkg::side_type    xf_side;
   logic [CW-1:0]        mag_x, mag_y, den;
   logic [rpc_pkg::QBITS-1:0] quot_x, quot_y;

   logic                 dly_valid_ff [rpc_pkg::DIV_LAT];
   rpc_pkg::side_type    dly_side_ff  [rpc_pkg::DIV_LAT];

   // The whole pipeline moves whenever the output register is free or drained.
   assign en         = !rsp_valid || !rsp_stall;
   assign req_stall  = !en;
   assign req_accept = req_valid && en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x       <= rpc_pkg::FOCAL_X_RESET;
         cfg_ff.focal_y       <= rpc_pkg::FOCAL_Y_RESET;
         cfg_ff.center_x      <= rpc_pkg::CENTER_X_RESET;
         cfg_ff.center_y      <= rpc_pkg::CENTER_Y_RESET;
         cfg_ff.inlier_radius <= rpc_pkg::INLIER_RADIUS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rpc_pkg::CSR_FOCAL_X:       cfg_ff.focal_x       <= csr_wr_data;
            rpc_pkg::CSR_FOCAL_Y:       cfg_ff.focal_y       <= csr_wr_data;
            rpc_pkg::CSR_CENTER_X:      cfg_ff.center_x      <= csr_wr_data;
            rpc_pkg::CSR_CENTER_Y:      cfg_ff.center_y      <= csr_wr_data;
            rpc_pkg::CSR_INLIER_RADIUS: cfg_ff.inlier_radius <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Pose words. A point reads them in its accept cycle, so a load placed
   // after it in the stream cannot reach it.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rpc_pkg::POSE_WORDS; i++) begin
            pose_ff[i] <= '0;
         end
      end else if (req_accept && req_word.op == rpc_pkg::OP_POSE
                   && req_word.pose_index < 4'(rpc_pkg::POSE_WORDS)) begin
         pose_ff[req_word.pose_index] <= req_word.pose_value;
      end
   end

   rpc_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_accept && req_word.op == rpc_pkg::OP_POINT),
      .in_word   (req_word),
      .pose      (pose_ff),
      .out_valid (xf_valid),
      .out_side  (xf_side),
      .out_mag_x (mag_x),
      .out_mag_y (mag_y),
      .out_den   (den)
   );

   rpc_divider #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (en),
      .focal (cfg_ff.focal_x),
      .mag   (mag_x),
      .den   (den),
      .quot  (quot_x)
   );

   rpc_divider #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (en),
      .focal (cfg_ff.focal_y),
      .mag   (mag_y),
      .den   (den),
      .quot  (quot_y)
   );

   // The per-point side information travels next to the dividers.
   always_ff @(posedge clock) begin
      if (en) begin
         dly_side_ff[0] <= xf_side;
         for (int i = 1; i < rpc_pkg::DIV_LAT; i++) begin
            dly_side_ff[i] <= dly_side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rpc_pkg::DIV_LAT; i++) begin
            dly_valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         dly_valid_ff[0] <= xf_valid;
         for (int i = 1; i < rpc_pkg::DIV_LAT; i++) begin
            dly_valid_ff[i] <= dly_valid_ff[i-1];
         end
      end
   end

   rpc_score #(.MAX_POINTS(MAX_POINTS)) u_score (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dly_valid_ff[rpc_pkg::DIV_LAT-1]),
      .in_side   (dly_side_ff[rpc_pkg::DIV_LAT-1]),
      .quot_x    (quot_x),
      .quot_y    (quot_y),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

`ifndef SYNTH
   // An inlier always has positive depth.
   a_inlier_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_word.is_inlier || rsp_word.depth_ok))
      else $error("inlier reported without positive depth");

   // The input side is held exactly when a response is waiting on a stall.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output backpressure");

   // An accepted pose load lands in the addressed word.
   a_pose_load: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_word.op == rpc_pkg::OP_POSE
       && req_word.pose_index < 4'(rpc_pkg::POSE_WORDS))
      |=> pose_ff[$past(req_word.pose_index)] == $past(req_word.pose_value))
      else $error("pose load lost");
`endif

endmodule

// ----- sv/rpc_transform.sv -----
module rpc_transform #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  rpc_pkg::req_word_type   in_word,
   input  logic [31:0]             pose [rpc_pkg::POSE_WORDS],
   output logic                    out_valid,
   output rpc_pkg::side_type       out_side,
   output logic [65-FRAC_BITS:0]   out_mag_x,
   output logic [65-FRAC_BITS:0]   out_mag_y,
   output logic [65-FRAC_BITS:0]   out_den
);

   localparam int CW = 66 - FRAC_BITS;

   logic signed [31:0] w [3];
   logic signed [63:0] prod_in [3][3];
   logic signed [63:0] prod_ff [3][3];
   logic signed [31:0] tr_ff [3];
   logic               valid1_ff, valid2_ff, valid3_ff;
   logic               first1_ff, first2_ff;
   logic               present1_ff, present2_ff;
   logic signed [31:0] ku1_ff, kv1_ff, ku2_ff, kv2_ff;
   logic signed [CW-1:0] coord_in [3];
   logic signed [CW-1:0] coord_ff [3];
   rpc_pkg::side_type  side_in, side3_ff;
   logic [CW-1:0]      mag_x_in, mag_y_in;
   logic [CW-1:0]      mag_x_ff, mag_y_ff, den_ff;

   assign w[0] = in_word.world_x;
   assign w[1] = in_word.world_y;
   assign w[2] = in_word.world_z;

   // Stage 1: the nine rotation products, taken against the pose as it stands at accept.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(pose[r*4+c]) * w[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= prod_in[r][c];
            end
            tr_ff[r] <= $signed(pose[r*4+3]);
         end
         first1_ff   <= in_word.first_point;
         present1_ff <= in_word.point_present;
         ku1_ff      <= in_word.key_u;
         kv1_ff      <= in_word.key_v;
      end
   end

   // Stage 2: floor-scaled products plus translation.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         coord_in[r] = CW'(prod_ff[r][0] >>> FRAC_BITS) + CW'(prod_ff[r][1] >>> FRAC_BITS)
                     + CW'(prod_ff[r][2] >>> FRAC_BITS) + CW'(tr_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            coord_ff[r] <= coord_in[r];
         end
         first2_ff   <= first1_ff;
         present2_ff <= present1_ff;
         ku2_ff      <= ku1_ff;
         kv2_ff      <= kv1_ff;
      end
   end

   // Stage 3: sign and magnitude for the divider, depth test.
   always_comb begin
      side_in.first_point = first2_ff;
      side_in.depth_ok    = present2_ff && (coord_ff[2] > 0);
      side_in.neg_x       = coord_ff[0][CW-1];
      side_in.neg_y       = coord_ff[1][CW-1];
      side_in.key_u       = ku2_ff;
      side_in.key_v       = kv2_ff;
      mag_x_in = side_in.neg_x ? CW'(-coord_ff[0]) : CW'(coord_ff[0]);
      mag_y_in = side_in.neg_y ? CW'(-coord_ff[1]) : CW'(coord_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff <= side_in;
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         den_ff   <= CW'(coord_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   assign out_valid = valid3_ff;
   assign out_side  = side3_ff;
   assign out_mag_x = mag_x_ff;
   assign out_mag_y = mag_y_ff;
   assign out_den   = den_ff;

endmodule

// ----- sv/rpc_divider.sv -----
module rpc_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [31:0]                focal,
   input  logic [65-FRAC_BITS:0]      mag,
   input  logic [65-FRAC_BITS:0]      den,
   output logic [rpc_pkg::QBITS-1:0]  quot
);

   localparam int CW = 66 - FRAC_BITS;
   localparam int NW = CW + 32;
   localparam int QB = rpc_pkg::QBITS;

   logic [63:0]    p0_ff;
   logic [CW-1:0]  p1_ff;
   logic [CW-1:0]  den4_ff, den5_ff;
   logic [NW-1:0]  num5_ff;

   logic [NW-1:0]  rem_ff [QB+1];
   logic [CW-1:0]  dsr_ff [QB+1];
   logic           sat_ff [QB+1];
   logic [QB-1:0]  q_ff   [QB+1];

   // The numerator is split into two partial products, then summed.
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff   <= 64'(focal) * 64'(mag[31:0]);
         p1_ff   <= CW'(focal) * CW'(mag[CW-1:32]);
         den4_ff <= den;
         num5_ff <= NW'(p0_ff) + (NW'(p1_ff) << 32);
         den5_ff <= den4_ff;
         sat_ff[0] <= num5_ff >= (NW'(den5_ff) << QB);
         rem_ff[0] <= num5_ff;
         dsr_ff[0] <= den5_ff;
         q_ff[0]   <= '0;
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [NW-1:0] shifted;
      logic          fit;
      logic [QB-1:0] q_next;

      always_comb begin
         shifted = NW'(dsr_ff[k-1]) << (QB - k);
         fit     = rem_ff[k-1] >= shifted;
         q_next  = q_ff[k-1];
         q_next[QB-k] = fit;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= fit ? rem_ff[k-1] - shifted : rem_ff[k-1];
            dsr_ff[k] <= dsr_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            q_ff[k]   <= q_next;
         end
      end
   end

   assign quot = sat_ff[QB] ? '1 : q_ff[QB];

endmodule

// ----- sv/rpc_score.sv -----
module rpc_score #(
   parameter int MAX_POINTS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rpc_pkg::side_type             in_side,
   input  logic [rpc_pkg::QBITS-1:0]     quot_x,
   input  logic [rpc_pkg::QBITS-1:0]     quot_y,
   input  rpc_pkg::cfg_type              cfg,
   output logic                          out_valid,
   output rpc_pkg::rsp_word_type         out_word
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic signed [34:0] qx_s, qy_s, dx_in, dy_in;
   logic signed [34:0] dx_ff, dy_ff;
   logic [34:0]        ax, ay;
   logic               near_in, near_ff;
   logic [63:0]        sx_ff, sy_ff, r2_ff;
   logic               valid_a_ff, valid_b_ff, valid_c_ff;
   rpc_pkg::side_type  side_a_ff, side_b_ff;
   logic               hit;
   logic [CNT_W-1:0]   cnt_ff, cnt_base, cnt_in;
   rpc_pkg::rsp_word_type word_ff;

   // Stage A: signed offsets from the keypoint.
   always_comb begin
      qx_s  = in_side.neg_x ? -$signed({4'b0, quot_x}) : $signed({4'b0, quot_x});
      qy_s  = in_side.neg_y ? -$signed({4'b0, quot_y}) : $signed({4'b0, quot_y});
      dx_in = qx_s + $signed({3'b0, cfg.center_x}) - 35'(in_side.key_u);
      dy_in = qy_s + $signed({3'b0, cfg.center_y}) - 35'(in_side.key_v);
   end

   // Stage B: magnitudes, coarse bound and the three squares.
   always_comb begin
      ax = dx_ff[34] ? 35'(-dx_ff) : 35'(dx_ff);
      ay = dy_ff[34] ? 35'(-dy_ff) : 35'(dy_ff);
      near_in = (ax <= {3'b0, cfg.inlier_radius}) && (ay <= {3'b0, cfg.inlier_radius});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         side_a_ff <= in_side;
         near_ff   <= near_in;
         sx_ff     <= 64'(ax[31:0]) * 64'(ax[31:0]);
         sy_ff     <= 64'(ay[31:0]) * 64'(ay[31:0]);
         r2_ff     <= 64'(cfg.inlier_radius) * 64'(cfg.inlier_radius);
         side_b_ff <= side_a_ff;
      end
   end

   // Stage C: final compare and the running count.
   always_comb begin
      hit = side_b_ff.depth_ok && near_ff
         && ({1'b0, sx_ff} + {1'b0, sy_ff} <= {1'b0, r2_ff});
      cnt_base = side_b_ff.first_point ? '0 : cnt_ff;
      cnt_in   = (hit && cnt_base < CNT_W'(MAX_POINTS)) ? cnt_base + 1'b1 : cnt_base;
   end

   always_ff @(posedge clock) begin
      if (en && valid_b_ff) begin
         word_ff.is_inlier    <= hit;
         word_ff.depth_ok     <= side_b_ff.depth_ok;
         word_ff.inlier_count <= 13'(cnt_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         cnt_ff     <= '0;
      end else if (en) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         if (valid_b_ff) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   assign out_valid = valid_c_ff;
   assign out_word  = word_ff;

endmodule

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC          = 16;
   localparam int COUNT_MAX     = 4096;
   // Settling time after the block answers its last point; leave margin.
   localparam int PIPE_SETTLE   = 60;
   localparam int WATCHDOG_MAX  = 5000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   rpc_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rpc_pkg::rsp_word_type rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [2:0]            csr_index = '0;
   logic [31:0]           csr_wr_data = '0;

   reprojection_inlier_check_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block state: camera registers, pose and inlier count.
   rpc_pkg::cfg_type   cam_regs;
   logic signed [31:0] pose_shadow [rpc_pkg::POSE_WORDS];
   int unsigned        inlier_tally;

   rpc_pkg::rsp_word_type pending_verdicts [$];
   int unsigned        mismatch_count = 0;
   int unsigned        sender_idle_pct = 0;
   int unsigned        receiver_stall_pct = 0;
   int unsigned        quiet_cycles = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // One row of the rigid transform: R row times the point, plus translation.
   // The arithmetic right shift of the exact product rounds toward minus
   // infinity, which is what the datapath does.
   function automatic longint camera_row(input int r, input rpc_pkg::req_word_type w);
      longint acc;
      longint coord [3];
      coord[0] = longint'(w.world_x);
      coord[1] = longint'(w.world_y);
      coord[2] = longint'(w.world_z);
      acc = longint'(pose_shadow[r*4+3]);
      for (int c = 0; c < 3; c++) begin
         acc += (longint'(pose_shadow[r*4+c]) * coord[c]) >>> FRAC;
      end
      return acc;
   endfunction

   // Focal length times numerator over depth, truncated toward zero and
   // clamped symmetrically to the largest positive 32-bit value.
   function automatic longint pinhole_offset(input logic [31:0] f, input longint num,
                                             input longint den);
      logic [127:0] mag;
      logic [127:0] quo;
      mag = (num < 0) ? 128'(-num) : 128'(num);
      quo = ({96'b0, f} * mag) / 128'(den);
      if (quo > 128'h7FFF_FFFF) begin
         quo = 128'h7FFF_FFFF;
      end
      return (num < 0) ? -longint'(quo[31:0]) : longint'(quo[31:0]);
   endfunction

   // Projected pixel of a point under the current pose and camera registers.
   function automatic bit project_pixel(input rpc_pkg::req_word_type w, output longint pu,
                                        output longint pv);
      longint xc, yc, zc;
      xc = camera_row(0, w);
      yc = camera_row(1, w);
      zc = camera_row(2, w);
      pu = 0;
      pv = 0;
      if (zc <= 0) begin
         return 1'b0;
      end
      pu = pinhole_offset(cam_regs.focal_x, xc, zc) + longint'(cam_regs.center_x);
      pv = pinhole_offset(cam_regs.focal_y, yc, zc) + longint'(cam_regs.center_y);
      return 1'b1;
   endfunction

   // Applies one accepted word to the shadow state and returns the verdict
   // that the block must give for it, if any.
   function automatic bit score_word(input rpc_pkg::req_word_type w,
                                     output rpc_pkg::rsp_word_type v);
      longint       pu, pv, dx, dy;
      logic [127:0] ax, ay, r2;
      bit           depth_pos;
      bit           hit;
      v = '0;
      if (w.op == rpc_pkg::OP_POSE) begin
         if (w.pose_index < rpc_pkg::POSE_WORDS) begin
            pose_shadow[w.pose_index] = w.pose_value;
         end
         return 1'b0;
      end
      if (w.first_point) begin
         inlier_tally = 0;
      end
      depth_pos = 1'b0;
      hit = 1'b0;
      if (w.point_present) begin
         depth_pos = project_pixel(w, pu, pv);
         if (depth_pos) begin
            dx = pu - longint'(w.key_u);
            dy = pv - longint'(w.key_v);
            ax = (dx < 0) ? 128'(-dx) : 128'(dx);
            ay = (dy < 0) ? 128'(-dy) : 128'(dy);
            r2 = 128'(cam_regs.inlier_radius) * 128'(cam_regs.inlier_radius);
            hit = (ax * ax + ay * ay) <= r2;
         end
      end
      if (hit && inlier_tally < COUNT_MAX) begin
         inlier_tally++;
      end
      v.is_inlier    = hit;
      v.depth_ok     = depth_pos;
      v.inlier_count = 13'(inlier_tally);
      return 1'b1;
   endfunction

   // Sends one word. Called at a falling edge and returns at a falling edge,
   // with valid still high so that back-to-back words need no extra step.
   task automatic send_word(input rpc_pkg::req_word_type w);
      rpc_pkg::rsp_word_type v;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (score_word(w, v)) begin
         pending_verdicts = {pending_verdicts, v};
      end
      @(negedge clock);
   endtask

   // Lets every point in flight come back, then allows for a trailing pose load.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_verdicts.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         rpc_pkg::CSR_FOCAL_X:       cam_regs.focal_x = value;
         rpc_pkg::CSR_FOCAL_Y:       cam_regs.focal_y = value;
         rpc_pkg::CSR_CENTER_X:      cam_regs.center_x = value;
         rpc_pkg::CSR_CENTER_Y:      cam_regs.center_y = value;
         rpc_pkg::CSR_INLIER_RADIUS: cam_regs.inlier_radius = value;
         default: ;
      endcase
   endtask

   task automatic send_pose(input int idx, input logic signed [31:0] value);
      rpc_pkg::req_word_type w;
      w = rpc_pkg::req_word_type'({7'($urandom), $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom});
      w.op         = rpc_pkg::OP_POSE;
      w.pose_index = 4'(idx);
      w.pose_value = value;
      send_word(w);
   endtask

   // A point whose keypoint lies near its projection, offset by up to spread.
   task automatic send_aimed_point(input logic signed [31:0] x, input logic signed [31:0] y,
                                   input logic signed [31:0] z, input bit first,
                                   input int spread);
      rpc_pkg::req_word_type w;
      longint       pu, pv;
      w = rpc_pkg::req_word_type'({7'($urandom), $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom});
      w.op            = rpc_pkg::OP_POINT;
      w.first_point   = first;
      w.point_present = 1'b1;
      w.world_x = x;
      w.world_y = y;
      w.world_z = z;
      void'(project_pixel(w, pu, pv));
      pu -= $signed($urandom_range(2 * spread)) - spread;
      pv -= $signed($urandom_range(2 * spread)) - spread;
      w.key_u = 32'(pu);
      w.key_v = 32'(pv);
      send_word(w);
   endtask

   task automatic load_identity_pose(input logic signed [31:0] tz);
      for (int i = 0; i < rpc_pkg::POSE_WORDS; i++) begin
         send_pose(i, (i == 0 || i == 5 || i == 10) ? 32'sd65536 : 32'sd0);
      end
      send_pose(11, tz);
   endtask

   task automatic test_directed();
      rpc_pkg::req_word_type w;
      load_identity_pose(32'sd5 <<< 16);
      // A point on the axis, exactly on its keypoint, restarting the count.
      send_aimed_point(0, 0, 0, 1'b1, 0);
      send_aimed_point(32'sd1 <<< 16, -(32'sd1 <<< 16), 0, 1'b0, 0);
      // Absent point: no projection, no count.
      w = '0;
      w.op = rpc_pkg::OP_POINT;
      w.point_present = 1'b0;
      send_word(w);
      // Depth exactly zero and below zero.
      send_aimed_point(0, 0, -(32'sd5 <<< 16), 1'b0, 0);
      send_aimed_point(0, 0, -(32'sd10 <<< 16), 1'b0, 0);
      // Pose indexes past the matrix are dropped.
      send_pose(12, 32'sh7FFF_FFFF);
      send_pose(15, 32'sh8000_0000);
      send_aimed_point(0, 0, 0, 1'b0, 0);
      // Huge lateral offset over tiny depth drives the quotient into saturation.
      send_aimed_point(32'sh7FFF_FFFF, 32'sh8000_0000, -(32'sd5 <<< 16) + 1, 1'b0, 0);
      // Field extremes on every coordinate and keypoint.
      w = '0;
      w.op = rpc_pkg::OP_POINT;
      w.point_present = 1'b1;
      w.world_x = 32'sh8000_0000;
      w.world_y = 32'sh7FFF_FFFF;
      w.world_z = 32'sh7FFF_FFFF;
      w.key_u   = 32'sh8000_0000;
      w.key_v   = 32'sh7FFF_FFFF;
      send_word(w);
      w.world_z = 32'sh8000_0000;
      w.key_u   = 32'sh7FFF_FFFF;
      w.key_v   = 32'sh8000_0000;
      send_word(w);
      // Extreme pose words.
      send_pose(0, 32'sh7FFF_FFFF);
      send_pose(6, 32'sh8000_0000);
      send_pose(11, 32'sh7FFF_FFFF);
      send_aimed_point(32'sd3 <<< 16, 32'sd2 <<< 16, 32'sd1 <<< 16, 1'b1, 2);
      send_aimed_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 2);
      wait_idle();
   endtask

   // Camera register extremes, with a few points under each setting. The
   // writes to indexes past the register list must change nothing.
   task automatic test_camera_registers();
      logic [31:0] corner [3];
      corner[0] = 32'h0;
      corner[1] = 32'hFFFF_FFFF;
      corner[2] = 32'h8000_0000;
      load_identity_pose(32'sd4 <<< 16);
      for (int k = 0; k < 3; k++) begin
         for (int r = rpc_pkg::CSR_FOCAL_X; r <= rpc_pkg::CSR_INLIER_RADIUS; r++) begin
            write_reg(3'(r), corner[k]);
            for (int p = 0; p < 3; p++) begin
               send_aimed_point($signed($urandom_range(1 << 18)) - (1 << 17),
                                $signed($urandom_range(1 << 18)) - (1 << 17),
                                $signed($urandom_range(1 << 18)), p == 0, 1 << p * 8);
            end
         end
      end
      for (int r = 5; r < 8; r++) begin
         write_reg(3'(r), $urandom);
      end
      write_reg(rpc_pkg::CSR_FOCAL_X, rpc_pkg::FOCAL_X_RESET);
      write_reg(rpc_pkg::CSR_FOCAL_Y, rpc_pkg::FOCAL_Y_RESET);
      write_reg(rpc_pkg::CSR_CENTER_X, rpc_pkg::CENTER_X_RESET);
      write_reg(rpc_pkg::CSR_CENTER_Y, rpc_pkg::CENTER_Y_RESET);
      write_reg(rpc_pkg::CSR_INLIER_RADIUS, rpc_pkg::INLIER_RADIUS_RESET);
   endtask

   // Random frames: a random pose, then mostly points aimed near their
   // projection, with some fully random words and stray pose loads mixed in.
   task automatic test_random_frames(input int n_items);
      rpc_pkg::req_word_type w;
      int sent;
      sent = 0;
      while (sent < n_items) begin
         for (int i = 0; i < 12; i++) begin
            if (i == 11) begin
               send_pose(i, $signed($urandom_range(40 << 16)) - (4 << 16));
            end else if (i % 4 == 3) begin
               send_pose(i, $signed($urandom_range(8 << 16)) - (4 << 16));
            end else begin
               send_pose(i, $signed($urandom_range(1 << 17)) - (1 << 16));
            end
         end
         for (int p = 0; p < 40 && sent < n_items; p++) begin
            case ($urandom_range(9))
               0: begin
                  w = rpc_pkg::req_word_type'({7'($urandom), $urandom, $urandom,
                                               $urandom, $urandom, $urandom, $urandom});
                  send_word(w);
               end
               1: begin
                  w = rpc_pkg::req_word_type'({7'($urandom), $urandom, $urandom,
                                               $urandom, $urandom, $urandom, $urandom});
                  w.op = rpc_pkg::OP_POINT;
                  send_word(w);
               end
               default: begin
                  send_aimed_point($signed($urandom_range(20 << 16)) - (10 << 16),
                                   $signed($urandom_range(20 << 16)) - (10 << 16),
                                   $signed($urandom_range(20 << 16)) - (10 << 16),
                                   p == 0 || $urandom_range(19) == 0,
                                   1 << $urandom_range(20));
               end
            endcase
            sent++;
         end
      end
   endtask

   // The four idling phases, each with fresh camera registers.
   task automatic test_flow_control();
      int unsigned idle_tab [4]  = '{0, 47, 0, 12};
      int unsigned stall_tab [4] = '{0, 0, 47, 12};
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(rpc_pkg::CSR_FOCAL_X, $urandom_range(32'h0400_0000, 32'h0040_0000));
         write_reg(rpc_pkg::CSR_FOCAL_Y, $urandom_range(32'h0400_0000, 32'h0040_0000));
         write_reg(rpc_pkg::CSR_CENTER_X, $urandom_range(32'h0200_0000));
         write_reg(rpc_pkg::CSR_CENTER_Y, $urandom_range(32'h0200_0000));
         write_reg(rpc_pkg::CSR_INLIER_RADIUS, $urandom_range(32'h0008_0000));
         sender_idle_pct    = idle_tab[ph];
         receiver_stall_pct = stall_tab[ph];
         test_random_frames(330);
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   // The receiver stalls at random, changing only at falling edges.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Every accepted verdict is matched against the oldest prediction.
   always @(posedge clock) begin
      rpc_pkg::rsp_word_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("verdict with no point outstanding");
         end else begin
            exp_v = pending_verdicts.pop_front();
            if (rsp_word.is_inlier !== exp_v.is_inlier)
               report_mismatch($sformatf("is_inlier %b, expected %b",
                                         rsp_word.is_inlier, exp_v.is_inlier));
            if (rsp_word.depth_ok !== exp_v.depth_ok)
               report_mismatch($sformatf("depth_ok %b, expected %b",
                                         rsp_word.depth_ok, exp_v.depth_ok));
            if (rsp_word.inlier_count !== exp_v.inlier_count)
               report_mismatch($sformatf("inlier_count %0d, expected %0d",
                                         rsp_word.inlier_count, exp_v.inlier_count));
         end
      end
   end

   // Watchdog: too long without any word moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      cam_regs.focal_x       = rpc_pkg::FOCAL_X_RESET;
      cam_regs.focal_y       = rpc_pkg::FOCAL_Y_RESET;
      cam_regs.center_x      = rpc_pkg::CENTER_X_RESET;
      cam_regs.center_y      = rpc_pkg::CENTER_Y_RESET;
      cam_regs.inlier_radius = rpc_pkg::INLIER_RADIUS_RESET;
      for (int i = 0; i < rpc_pkg::POSE_WORDS; i++) begin
         pose_shadow[i] = '0;
      end
      inlier_tally = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_camera_registers();
      test_flow_control();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
